// ===== sv/triangle_attribute_gradient_setup_macros.svh =====
// Assertion macros used by the triangle gradient setup controller.
`ifndef TRIANGLE_ATTRIBUTE_GRADIENT_SETUP_MACROS_SVH
`define TRIANGLE_ATTRIBUTE_GRADIENT_SETUP_MACROS_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define TAGS_ASSERT_HOLDS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tags: same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define TAGS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tags: next-cycle check failed");
`else
`define TAGS_ASSERT_HOLDS(lbl, ante, cons)
`define TAGS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/tags_pkg.sv =====
// Types, constants and helpers for the triangle gradient setup block.
`timescale 1ns / 1ps
package tags_pkg;

	// Divider widths: dividend covers 2^40 and |num|*16, divisor covers |area|
	localparam int NUM_W = 54;
	localparam int DEN_W = 34;

	localparam logic [1:0] LAST_ATTR = 2'd3;
	localparam logic [1:0] LAST_VTX  = 2'd2;
	localparam logic [1:0] FIRST_VTX = 2'd0;

	localparam logic [1:0] ATTR_U   = 2'd0;
	localparam logic [1:0] ATTR_V   = 2'd1;
	localparam logic [1:0] ATTR_Z   = 2'd2;
	localparam logic [1:0] ATTR_INV = 2'd3;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_DIVW, OP_INV, OP_MUL_U, OP_ST_U, OP_MUL_V, OP_ST_V,
		OP_GEOM, OP_AREA_A, OP_AREA_B, OP_AREA_C, OP_DIFF,
		OP_G1, OP_G2, OP_G3, OP_G4, OP_G5,
		OP_DIVX, OP_GX, OP_DIVY, OP_GY, OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DIVW, S_WAITW, S_MULU, S_STU, S_MULV, S_STV,
		S_GEOM, S_AR1, S_AR2, S_AR3, S_DIFF,
		S_G1, S_G2, S_G3, S_G4, S_G5,
		S_DIVX, S_WAITX, S_DIVY, S_WAITY, S_OUT, S_HOLD
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] vidx;
		logic [1:0] attr;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

	// Clamp a wide signed value to signed 32 bits
	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		logic [31:0] r;
		if (v > 64'sd2147483647) r = 32'h7fff_ffff;
		else if (v < -64'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	// Apply sign to a quotient magnitude and clamp to signed 32 bits
	function automatic logic [31:0] qsat(input logic [NUM_W-1:0] m, input logic neg);
		logic [31:0] r;
		if (neg) begin
			if (m > NUM_W'(64'h8000_0000)) r = 32'h8000_0000;
			else r = ~m[31:0] + 32'd1;
		end else begin
			if (m > NUM_W'(64'h7fff_ffff)) r = 32'h7fff_ffff;
			else r = m[31:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/tags_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tags_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tags_pkg::NUM_W-1:0]  dividend,
	input  logic [tags_pkg::DEN_W-1:0]  divisor,
	output logic                        done,
	output logic [tags_pkg::NUM_W-1:0]  quotient
);
	import tags_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh, rem_nx;
	logic             ge;

	// One restoring step
	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
	end

	// Control: count steps, pulse done after the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: shift dividend out, quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// ===== sv/tags_ctrl.sv =====
// Sequencer for vertex intake, area setup and per-attribute gradients.
`timescale 1ns / 1ps
`include "triangle_attribute_gradient_setup_macros.svh"
module tags_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output tags_pkg::cmd_t  cmd,
	input  tags_pkg::stat_t stat
);
	import tags_pkg::*;

	state_t     state_q, state_d;
	logic [1:0] vcnt_q, vcnt_d;
	logic [1:0] attr_q, attr_d;
	op_t        op;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcnt_q  <= FIRST_VTX;
			attr_q  <= ATTR_U;
		end else begin
			state_q <= state_d;
			vcnt_q  <= vcnt_d;
			attr_q  <= attr_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		vcnt_d  = vcnt_q;
		attr_d  = attr_q;
		op      = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_DIVW;
				end
			end
			S_DIVW: begin
				op      = OP_DIVW;
				state_d = S_WAITW;
			end
			S_WAITW: begin
				if (stat.div_done) begin
					op      = OP_INV;
					state_d = S_MULU;
				end
			end
			S_MULU: begin
				op      = OP_MUL_U;
				state_d = S_STU;
			end
			S_STU: begin
				op      = OP_ST_U;
				state_d = S_MULV;
			end
			S_MULV: begin
				op      = OP_MUL_V;
				state_d = S_STV;
			end
			S_STV: begin
				op = OP_ST_V;
				if (vcnt_q == LAST_VTX) begin
					vcnt_d  = FIRST_VTX;
					state_d = S_GEOM;
				end else begin
					vcnt_d  = vcnt_q + 2'd1;
					state_d = S_IDLE;
				end
			end
			S_GEOM: begin
				op      = OP_GEOM;
				state_d = S_AR1;
			end
			S_AR1: begin
				op      = OP_AREA_A;
				state_d = S_AR2;
			end
			S_AR2: begin
				op      = OP_AREA_B;
				state_d = S_AR3;
			end
			S_AR3: begin
				op      = OP_AREA_C;
				attr_d  = ATTR_U;
				state_d = S_DIFF;
			end
			S_DIFF: begin
				op      = OP_DIFF;
				state_d = S_G1;
			end
			S_G1: begin
				op      = OP_G1;
				state_d = S_G2;
			end
			S_G2: begin
				op      = OP_G2;
				state_d = S_G3;
			end
			S_G3: begin
				op      = OP_G3;
				state_d = S_G4;
			end
			S_G4: begin
				op      = OP_G4;
				state_d = S_G5;
			end
			S_G5: begin
				op      = OP_G5;
				state_d = S_DIVX;
			end
			S_DIVX: begin
				op      = OP_DIVX;
				state_d = S_WAITX;
			end
			S_WAITX: begin
				if (stat.div_done) begin
					op      = OP_GX;
					state_d = S_DIVY;
				end
			end
			S_DIVY: begin
				op      = OP_DIVY;
				state_d = S_WAITY;
			end
			S_WAITY: begin
				if (stat.div_done) begin
					op      = OP_GY;
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				op      = OP_OUT;
				state_d = S_HOLD;
			end
			S_HOLD: begin
				// Hold the result until the transfer, then advance
				if (out_ready) begin
					if (attr_q == LAST_ATTR) begin
						state_d = S_IDLE;
					end else begin
						attr_d  = attr_q + 2'd1;
						state_d = S_DIFF;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_HOLD);
	assign cmd       = '{op: op, vidx: vcnt_q, attr: attr_q};

	`TAGS_ASSERT_HOLDS(a_io_excl, in_ready, !out_valid)
	`TAGS_ASSERT_HOLDS(a_vcnt_range, 1'b1, vcnt_q != 2'd3)
	`TAGS_ASSERT_NEXT(a_last_to_idle, out_valid && out_ready && attr_q == LAST_ATTR, in_ready)
	`TAGS_ASSERT_NEXT(a_load_count, in_valid && in_ready, vcnt_q == $past(vcnt_q))
endmodule

// ===== sv/tags_dp.sv =====
// Datapath: vertex stores, shared multiplier, divider and result registers.
`timescale 1ns / 1ps
module tags_dp #(
	parameter int ATTRIBUTE_FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tags_pkg::cmd_t     cmd,
	output tags_pkg::stat_t    stat,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	input  logic signed [31:0] vertex_w,
	input  logic signed [15:0] tex_u,
	input  logic signed [15:0] tex_v,
	output logic [1:0]         attribute_id,
	output logic signed [31:0] value_first,
	output logic signed [31:0] value_second,
	output logic signed [31:0] value_third,
	output logic signed [31:0] x_gradient,
	output logic signed [31:0] y_gradient,
	output logic               degenerate,
	output logic               bad_w,
	output logic               last
);
	import tags_pkg::*;

	localparam int ZL     = (ATTRIBUTE_FRACTION_BITS >= 16) ? ATTRIBUTE_FRACTION_BITS - 16 : 0;
	localparam int ZR     = (ATTRIBUTE_FRACTION_BITS >= 16) ? 0 : 16 - ATTRIBUTE_FRACTION_BITS;
	localparam int INV_SH = 16 + ATTRIBUTE_FRACTION_BITS;

	// Per-vertex stores
	logic signed [15:0] x_q [3];
	logic signed [15:0] y_q [3];
	logic [31:0]        z_q [3];
	logic [31:0]        inv_q [3];
	logic [31:0]        uw_q [3];
	logic [31:0]        vw_q [3];

	logic signed [15:0] u_q, v_q;
	logic signed [31:0] w_q;
	logic               bad_seen_q;

	logic signed [16:0] dx0_q, dx1_q, dy0_q, dy1_q;
	logic signed [32:0] d0_q, d1_q;
	logic signed [51:0] prod_q, acc_q;
	logic signed [34:0] area_q;
	logic signed [49:0] numx_q, numy_q;
	logic [31:0]        gx_q, gy_q;

	logic signed [33:0] ma;
	logic signed [17:0] mb;
	logic signed [51:0] prod_c;
	logic signed [63:0] zs;
	logic signed [51:0] prod_sh;
	logic [31:0]        a0, a1, a2;
	logic               flat;

	logic               div_start, div_done;
	logic [NUM_W-1:0]   dvd, quo;
	logic [DEN_W-1:0]   dvs;
	logic [49:0]        numx_mag, numy_mag;
	logic [DEN_W-1:0]   area_mag;

	// Shared multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.op)
			OP_MUL_U:  begin ma = signed'({2'b00, inv_q[cmd.vidx]}); mb = 18'(u_q); end
			OP_MUL_V:  begin ma = signed'({2'b00, inv_q[cmd.vidx]}); mb = 18'(v_q); end
			OP_AREA_A: begin ma = 34'(dx1_q); mb = 18'(dy0_q); end
			OP_AREA_B: begin ma = 34'(dx0_q); mb = 18'(dy1_q); end
			OP_G1:     begin ma = 34'(d1_q);  mb = 18'(dy0_q); end
			OP_G2:     begin ma = 34'(d0_q);  mb = 18'(dy1_q); end
			OP_G3:     begin ma = 34'(d1_q);  mb = 18'(dx0_q); end
			OP_G4:     begin ma = 34'(d0_q);  mb = 18'(dx1_q); end
			default:   begin ma = '0; mb = '0; end
		endcase
		prod_c = 52'(ma) * 52'(mb);
	end

	// Attribute select for gradient setup
	always_comb begin
		unique case (cmd.attr)
			ATTR_U:   begin a0 = uw_q[0];  a1 = uw_q[1];  a2 = uw_q[2];  end
			ATTR_V:   begin a0 = vw_q[0];  a1 = vw_q[1];  a2 = vw_q[2];  end
			ATTR_Z:   begin a0 = z_q[0];   a1 = z_q[1];   a2 = z_q[2];   end
			default:  begin a0 = inv_q[0]; a1 = inv_q[1]; a2 = inv_q[2]; end
		endcase
	end

	// Depth rescale, floor on right shift
	assign zs      = (64'(vertex_z) <<< ZL) >>> ZR;
	assign prod_sh = prod_q >>> 14;
	assign flat    = (area_q == '0) || bad_seen_q;

	// Divider operand select
	assign numx_mag  = numx_q[49] ? 50'(-numx_q) : 50'(numx_q);
	assign numy_mag  = numy_q[49] ? 50'(-numy_q) : 50'(numy_q);
	assign area_mag  = area_q[34] ? DEN_W'(-area_q) : DEN_W'(area_q);
	assign div_start = (cmd.op == OP_DIVW) || (cmd.op == OP_DIVX) || (cmd.op == OP_DIVY);
	always_comb begin
		unique case (cmd.op)
			OP_DIVW: begin dvd = NUM_W'(1) << INV_SH;  dvs = DEN_W'(w_q); end
			OP_DIVX: begin dvd = {numx_mag, 4'b0000}; dvs = area_mag; end
			default: begin dvd = {numy_mag, 4'b0000}; dvs = area_mag; end
		endcase
	end

	tags_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quo)
	);

	assign stat = '{div_done: div_done};

	// Bad-w flag for the current triangle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_seen_q <= 1'b0;
		end else if (cmd.op == OP_LOAD) begin
			bad_seen_q <= ((cmd.vidx == FIRST_VTX) ? 1'b0 : bad_seen_q) | (vertex_w <= 32'sd0);
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		unique case (cmd.op)
			OP_LOAD: begin
				x_q[cmd.vidx] <= vertex_x;
				y_q[cmd.vidx] <= vertex_y;
				z_q[cmd.vidx] <= sat32(zs);
				u_q <= tex_u;
				v_q <= tex_v;
				w_q <= vertex_w;
			end
			OP_INV: begin
				if (w_q <= 32'sd0) inv_q[cmd.vidx] <= '0;
				else if (quo > NUM_W'(64'h7fff_ffff)) inv_q[cmd.vidx] <= 32'h7fff_ffff;
				else inv_q[cmd.vidx] <= quo[31:0];
			end
			OP_ST_U: uw_q[cmd.vidx] <= sat32(64'(prod_sh));
			OP_ST_V: vw_q[cmd.vidx] <= sat32(64'(prod_sh));
			OP_GEOM: begin
				dx0_q <= 17'(x_q[0]) - 17'(x_q[2]);
				dx1_q <= 17'(x_q[1]) - 17'(x_q[2]);
				dy0_q <= 17'(y_q[0]) - 17'(y_q[2]);
				dy1_q <= 17'(y_q[1]) - 17'(y_q[2]);
			end
			OP_AREA_B: acc_q  <= prod_q;
			OP_AREA_C: area_q <= 35'(acc_q - prod_q);
			OP_DIFF: begin
				d0_q <= 33'(signed'(a0)) - 33'(signed'(a2));
				d1_q <= 33'(signed'(a1)) - 33'(signed'(a2));
			end
			OP_G2: acc_q  <= prod_q;
			OP_G3: numx_q <= 50'(acc_q - prod_q);
			OP_G4: acc_q  <= prod_q;
			OP_G5: numy_q <= 50'(acc_q - prod_q);
			OP_GX: gx_q <= flat ? 32'd0 : qsat(quo, numx_q[49] ^ area_q[34]);
			OP_GY: gy_q <= flat ? 32'd0 : qsat(quo, numy_q[49] ^ ~area_q[34]);
			OP_OUT: begin
				attribute_id <= cmd.attr;
				value_first  <= a0;
				value_second <= a1;
				value_third  <= a2;
				x_gradient   <= gx_q;
				y_gradient   <= gy_q;
				degenerate   <= (area_q == '0);
				bad_w        <= bad_seen_q;
				last         <= (cmd.attr == LAST_ATTR);
			end
			default: ;
		endcase
	end
endmodule

// ===== sv/triangle_attribute_gradient_setup.sv =====
// Top level of the triangle attribute gradient setup block.
`timescale 1ns / 1ps
// Takes a triangle as three vertex transfers and, after the third, returns four results
// (u/w, v/w, depth, 1/w), each with the three vertex values and Q16.16-style x and y
// gradients, saturated. One vertex is taken at a time, and each vertex waits on the
// bit-serial divider that forms 1/w (54 steps). After the third vertex, the geometry
// differences, the two area products and their difference form the area term; then
// each attribute forms its gradients by two 54-step divisions of the gradient
// numerators by the area term and holds its result until the receiver takes it.
// The next vertex is taken once the last result has transferred.
module triangle_attribute_gradient_setup #(
	parameter int ATTRIBUTE_FRACTION_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] vertex_x,
	input  logic signed [15:0] vertex_y,
	input  logic signed [31:0] vertex_z,
	input  logic signed [31:0] vertex_w,
	input  logic signed [15:0] tex_u,
	input  logic signed [15:0] tex_v,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         attribute_id,
	output logic signed [31:0] value_first,
	output logic signed [31:0] value_second,
	output logic signed [31:0] value_third,
	output logic signed [31:0] x_gradient,
	output logic signed [31:0] y_gradient,
	output logic               degenerate,
	output logic               bad_w,
	output logic               last
);
	import tags_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	tags_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	tags_dp #(
		.ATTRIBUTE_FRACTION_BITS (ATTRIBUTE_FRACTION_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.vertex_w     (vertex_w),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.attribute_id (attribute_id),
		.value_first  (value_first),
		.value_second (value_second),
		.value_third  (value_third),
		.x_gradient   (x_gradient),
		.y_gradient   (y_gradient),
		.degenerate   (degenerate),
		.bad_w        (bad_w),
		.last         (last)
	);
endmodule
